@@ hw/rtl/rseb_pkg.sv @@
// Shared constants for the radiative surface energy balance block.
package rseb_pkg;

  localparam int FLUX_W    = 40;  // signed flux, 1/16 W/m2
  localparam int FRAC_W    = 16;  // emissivity / absorptivity, Q0.16
  localparam int FACTOR_W  = 16;  // flux factor, Q4.12
  localparam int SIGMA_W   = 24;  // sigma, 2^-48 W/m2/K^4
  localparam int COND_W    = 24;  // k_normal and inverse_spacing
  localparam int G_W       = 48;  // wall conductance, Q28.20
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 24;

  localparam int EMIS_SHIFT = 76;
  localparam int ABS_SHIFT  = 28;
  localparam int G_FRAC     = 20;

  localparam logic [CFG_IDX_W-1:0] REG_FLUX_FACTOR      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEFAN_BOLTZMANN = 8'd1;

  localparam logic [FACTOR_W-1:0] FLUX_FACTOR_RST = 16'd4096;
  localparam logic [SIGMA_W-1:0]  SIGMA_RST       = 24'd15960680;

endpackage

@@ hw/rtl/radiative_surface_energy_balance.sv @@
// Pipelined surface energy balance for one boundary face per transaction.
//
// Each input transaction carries one face; one result transaction comes out
// per face, in order. The datapath is a fixed pipeline of 10 + ceil((TEMP_WIDTH+1)/4)
// register stages: seven stages for the fourth powers, the emission and
// absorption products and the flux sum, a restoring divider that resolves
// four quotient bits per stage, then the temperature update and the
// conduction product, and an output register.
// A new face is accepted every cycle; when the output is held the whole
// pipeline holds with it, so s_axis_tready follows m_axis_tready while a
// result is pending. Registers flux_factor (index 0) and stefan_boltzmann
// (index 1) are written through the cfg channel, which is always ready;
// write them only while no face is in flight. Fluxes saturate to 40 bits
// and the temperature to its range, setting saturated_flag; a zero
// conductance holds the face at the interior temperature and sets
// zero_conductance.
module radiative_surface_energy_balance #(
  parameter int TEMP_WIDTH = 18
) (
  input  logic clk,
  input  logic rst,
  // tdata, low bit up: face_temp_old, interior_temp, background_temp,
  // incoming_flux, emissivity_value, absorptivity_value, k_normal,
  // inverse_spacing, zero fill
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  logic [((3*TEMP_WIDTH+120+7)/8)*8-1:0]        s_axis_tdata,
  // tdata, low bit up: new_face_temp, emission_flux, absorption_flux,
  // conduction_flux, saturated_flag, zero_conductance, zero fill
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  output logic [((TEMP_WIDTH+122+7)/8)*8-1:0]          m_axis_tdata,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [rseb_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [rseb_pkg::CFG_DATA_W-1:0]              cfg_data
);

  localparam int TW    = TEMP_WIDTH;
  localparam int FW    = rseb_pkg::FLUX_W;
  localparam int GW    = rseb_pkg::G_W;
  localparam int IN_W  = ((3*TW+120+7)/8)*8;
  localparam int OUT_W = ((TW+122+7)/8)*8;

  // input field offsets
  localparam int O_TINT = TW;
  localparam int O_TB   = 2*TW;
  localparam int O_Q    = 3*TW;
  localparam int O_EPS  = O_Q + FW;
  localparam int O_ALP  = O_EPS + 16;
  localparam int O_K    = O_ALP + 16;
  localparam int O_INV  = O_K + 24;

  localparam int SQW   = 2*TW;
  localparam int PW    = 2*TW + 1;
  localparam int QW    = 2*TW + 1;
  localparam int QH    = TW + 1;
  localparam int QHW   = QW - QH;
  localparam int DIFFW = 4*TW;
  localparam int DH    = DIFFW / 2;
  localparam int ESW   = rseb_pkg::FRAC_W + rseb_pkg::SIGMA_W;
  localparam int ESH   = ESW / 2;
  localparam int EW    = DIFFW + ESW;
  localparam int EVW   = (EW - rseb_pkg::EMIS_SHIFT > FW + 1) ?
                         EW - rseb_pkg::EMIS_SHIFT : FW + 1;
  localparam int ABW   = rseb_pkg::FACTOR_W + rseb_pkg::FRAC_W;
  localparam int AW    = FW + ABW;
  localparam int AVW   = AW - rseb_pkg::ABS_SHIFT;
  localparam int NQ    = TW + 1;
  localparam int NUMW  = FW + 1 + rseb_pkg::G_FRAC;
  localparam int RW    = (NUMW > GW + NQ) ? NUMW : GW + NQ;
  localparam int DIV_BITS = 4;
  localparam int NST   = (NQ + DIV_BITS - 1) / DIV_BITS;
  localparam int TNW   = TW + 3;
  localparam int GH    = GW / 2;
  localparam int CPW   = GW + TW;
  localparam int CVW   = (CPW - rseb_pkg::G_FRAC > FW + 1) ?
                         CPW - rseb_pkg::G_FRAC : FW + 1;

  localparam logic [FW-1:0] LIM_POS = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] LIM_NEG = {1'b1, {(FW-1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic [rseb_pkg::FACTOR_W-1:0] flux_factor;
  logic [rseb_pkg::SIGMA_W-1:0]  stefan_boltzmann;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flux_factor      <= rseb_pkg::FLUX_FACTOR_RST;
      stefan_boltzmann <= rseb_pkg::SIGMA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rseb_pkg::REG_FLUX_FACTOR:      flux_factor <= cfg_data[rseb_pkg::FACTOR_W-1:0];
        rseb_pkg::REG_STEFAN_BOLTZMANN: stefan_boltzmann <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output slot is free or being taken
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------- stage 1
  logic [TW-1:0] in_t, in_tint, in_tb, c1_tl, c1_ts;
  logic [FW-1:0] in_q;
  assign in_t    = s_axis_tdata[TW-1:0];
  assign in_tint = s_axis_tdata[O_TINT +: TW];
  assign in_tb   = s_axis_tdata[O_TB +: TW];
  assign in_q    = s_axis_tdata[O_Q +: FW];
  assign c1_tl   = (in_t >= in_tb) ? in_t : in_tb;
  assign c1_ts   = (in_t >= in_tb) ? in_tb : in_t;

  logic            v1;
  logic [TW-1:0]   r1_d1, r1_tint;
  logic [TW:0]     r1_s1;
  logic [SQW-1:0]  r1_sql, r1_sqs;
  logic [ESW-1:0]  r1_es;
  logic [ABW-1:0]  r1_ab;
  logic [FW-1:0]   r1_qmag;
  logic            r1_qneg, r1_eneg;
  logic [GW-1:0]   r1_g;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_d1   <= c1_tl - c1_ts;
      r1_s1   <= {1'b0, c1_tl} + {1'b0, c1_ts};
      r1_sql  <= SQW'(c1_tl) * SQW'(c1_tl);
      r1_sqs  <= SQW'(c1_ts) * SQW'(c1_ts);
      r1_es   <= ESW'(s_axis_tdata[O_EPS +: 16]) * ESW'(stefan_boltzmann);
      r1_ab   <= ABW'(s_axis_tdata[O_ALP +: 16]) * ABW'(flux_factor);
      r1_qneg <= in_q[FW-1];
      r1_qmag <= in_q[FW-1] ? (~in_q + FW'(1)) : in_q;
      r1_eneg <= in_t > in_tb;
      r1_g    <= GW'(s_axis_tdata[O_K +: 24]) * GW'(s_axis_tdata[O_INV +: 24]);
      r1_tint <= in_tint;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic            v2;
  logic [PW-1:0]   r2_p;
  logic [QW-1:0]   r2_q;
  logic [ABW+19:0] r2_alo, r2_ahi;
  logic [ESW-1:0]  r2_es;
  logic            r2_qneg, r2_eneg;
  logic [GW-1:0]   r2_g;
  logic [TW-1:0]   r2_tint;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_p    <= PW'(r1_d1) * PW'(r1_s1);
      r2_q    <= QW'(r1_sql) + QW'(r1_sqs);
      r2_alo  <= (ABW+20)'(r1_qmag[19:0]) * (ABW+20)'(r1_ab);
      r2_ahi  <= (ABW+20)'(r1_qmag[39:20]) * (ABW+20)'(r1_ab);
      r2_es   <= r1_es;
      r2_qneg <= r1_qneg;
      r2_eneg <= r1_eneg;
      r2_g    <= r1_g;
      r2_tint <= r1_tint;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [AW-1:0]  c3_aprod;
  logic [AVW-1:0] c3_av;
  logic [FW-1:0]  c3_lim, c3_am;
  logic           c3_clip;
  assign c3_aprod = AW'(r2_alo) + (AW'(r2_ahi) << 20);
  assign c3_av    = AVW'(c3_aprod >> rseb_pkg::ABS_SHIFT);
  assign c3_lim   = r2_qneg ? LIM_NEG : LIM_POS;
  assign c3_clip  = c3_av > AVW'(c3_lim);
  assign c3_am    = c3_clip ? c3_lim : c3_av[FW-1:0];

  logic              v3;
  logic [PW+QH-1:0]  r3_pplo;
  logic [PW+QHW-1:0] r3_pphi;
  logic [FW-1:0]     r3_absb;
  logic              r3_aclip, r3_eneg;
  logic [ESW-1:0]    r3_es;
  logic [GW-1:0]     r3_g;
  logic [TW-1:0]     r3_tint;

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_pplo  <= (PW+QH)'(r2_p) * (PW+QH)'(r2_q[QH-1:0]);
      r3_pphi  <= (PW+QHW)'(r2_p) * (PW+QHW)'(r2_q[QW-1:QH]);
      r3_absb  <= r2_qneg ? (~c3_am + FW'(1)) : c3_am;
      r3_aclip <= c3_clip;
      r3_eneg  <= r2_eneg;
      r3_es    <= r2_es;
      r3_g     <= r2_g;
      r3_tint  <= r2_tint;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [PW+QW-1:0] c4_diff;
  assign c4_diff = (PW+QW)'(r3_pplo) + ((PW+QW)'(r3_pphi) << QH);

  logic             v4;
  logic [DIFFW-1:0] r4_diff;
  logic [FW-1:0]    r4_absb;
  logic             r4_aclip, r4_eneg;
  logic [ESW-1:0]   r4_es;
  logic [GW-1:0]    r4_g;
  logic [TW-1:0]    r4_tint;

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_diff  <= c4_diff[DIFFW-1:0];
      r4_absb  <= r3_absb;
      r4_aclip <= r3_aclip;
      r4_eneg  <= r3_eneg;
      r4_es    <= r3_es;
      r4_g     <= r3_g;
      r4_tint  <= r3_tint;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // emission product as four partial products, halves of diff by halves of eps*sigma
  logic                v5;
  logic [DH+ESH-1:0]   r5_e00, r5_e01, r5_e10, r5_e11;
  logic [FW-1:0]       r5_absb;
  logic                r5_aclip, r5_eneg;
  logic [GW-1:0]       r5_g;
  logic [TW-1:0]       r5_tint;

  always_ff @(posedge clk) begin
    if (adv) begin
      r5_e00   <= (DH+ESH)'(r4_diff[DH-1:0]) * (DH+ESH)'(r4_es[ESH-1:0]);
      r5_e01   <= (DH+ESH)'(r4_diff[DIFFW-1:DH]) * (DH+ESH)'(r4_es[ESH-1:0]);
      r5_e10   <= (DH+ESH)'(r4_diff[DH-1:0]) * (DH+ESH)'(r4_es[ESW-1:ESH]);
      r5_e11   <= (DH+ESH)'(r4_diff[DIFFW-1:DH]) * (DH+ESH)'(r4_es[ESW-1:ESH]);
      r5_absb  <= r4_absb;
      r5_aclip <= r4_aclip;
      r5_eneg  <= r4_eneg;
      r5_g     <= r4_g;
      r5_tint  <= r4_tint;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [EW-1:0]  c6_eprod;
  logic [EVW-1:0] c6_ev;
  logic [FW-1:0]  c6_lim, c6_em;
  logic           c6_clip;
  assign c6_eprod = EW'(r5_e00) + (EW'(r5_e01) << DH) + (EW'(r5_e10) << ESH)
                  + (EW'(r5_e11) << (DH + ESH));
  assign c6_ev    = EVW'(c6_eprod >> rseb_pkg::EMIS_SHIFT);
  assign c6_lim   = r5_eneg ? LIM_NEG : LIM_POS;
  assign c6_clip  = c6_ev > EVW'(c6_lim);
  assign c6_em    = c6_clip ? c6_lim : c6_ev[FW-1:0];

  logic          v6;
  logic [FW-1:0] r6_emis, r6_absb;
  logic          r6_clip;
  logic [GW-1:0] r6_g;
  logic [TW-1:0] r6_tint;

  always_ff @(posedge clk) begin
    if (adv) begin
      r6_emis <= r5_eneg ? (~c6_em + FW'(1)) : c6_em;
      r6_absb <= r5_absb;
      r6_clip <= c6_clip | r5_aclip;
      r6_g    <= r5_g;
      r6_tint <= r5_tint;
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic [FW:0] c7_sum, c7_mag;
  assign c7_sum = {r6_emis[FW-1], r6_emis} + {r6_absb[FW-1], r6_absb};
  assign c7_mag = c7_sum[FW] ? (~c7_sum + (FW+1)'(1)) : c7_sum;

  typedef struct packed {
    logic [TW-1:0] tint;
    logic [GW-1:0] g;
    logic          sneg;
    logic          zero_g;
    logic          clip;
    logic [FW-1:0] emis;
    logic [FW-1:0] absb;
  } carry_t;

  logic          v7;
  logic [RW-1:0] r7_num;
  carry_t        r7_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      r7_num      <= RW'(c7_mag) << rseb_pkg::G_FRAC;
      r7_c.tint   <= r6_tint;
      r7_c.g      <= r6_g;
      r7_c.sneg   <= c7_sum[FW];
      r7_c.zero_g <= r6_g == '0;
      r7_c.clip   <= r6_clip;
      r7_c.emis   <= r6_emis;
      r7_c.absb   <= r6_absb;
    end
  end

  // ---------------------------------------------------------------- divider
  // Quotient fits in NQ bits unless num >= g << NQ; that case clips anyway.
  logic          dv_v    [NST];
  logic [RW-1:0] dv_rem  [NST];
  logic [NQ-1:0] dv_q    [NST];
  logic          dv_over [NST];
  carry_t        dv_c    [NST];

  for (genvar j = 0; j < NST; j++) begin : g_div
    logic [RW-1:0] rem_in, rem_c;
    logic [NQ-1:0] q_in, q_c;
    logic          over_in;
    carry_t        c_in;

    if (j == 0) begin : g_first
      assign rem_in  = r7_num;
      assign q_in    = '0;
      assign over_in = r7_num >= (RW'(r7_c.g) << NQ);
      assign c_in    = r7_c;
    end else begin : g_next
      assign rem_in  = dv_rem[j-1];
      assign q_in    = dv_q[j-1];
      assign over_in = dv_over[j-1];
      assign c_in    = dv_c[j-1];
    end

    always_comb begin
      int bi;
      rem_c = rem_in;
      q_c   = q_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        bi = NQ - 1 - j*DIV_BITS - k;
        if (bi >= 0) begin
          if (rem_c >= (RW'(c_in.g) << bi)) begin
            rem_c = rem_c - (RW'(c_in.g) << bi);
            q_c   = q_c | (NQ'(1) << bi);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j]  <= rem_c;
        dv_q[j]    <= q_c;
        dv_over[j] <= over_in;
        dv_c[j]    <= c_in;
      end
    end
  end

  // ---------------------------------------------------------------- stage 8
  carry_t         c8;
  logic [TNW-1:0] c8_tn;
  logic           c8_low, c8_high;
  logic [TW-1:0]  c8_tnew;
  logic           c8_tclip;
  assign c8      = dv_c[NST-1];
  assign c8_tn   = c8.sneg ? (TNW'(c8.tint) - TNW'(dv_q[NST-1]))
                           : (TNW'(c8.tint) + TNW'(dv_q[NST-1]));
  assign c8_low  = dv_over[NST-1] ? c8.sneg : c8_tn[TNW-1];
  assign c8_high = dv_over[NST-1] ? !c8.sneg
                 : (!c8_tn[TNW-1] && (c8_tn > TNW'({TW{1'b1}})));
  assign c8_tnew = c8.zero_g ? c8.tint
                 : c8_low ? '0
                 : c8_high ? {TW{1'b1}}
                 : c8_tn[TW-1:0];
  assign c8_tclip = !c8.zero_g && (c8_low || c8_high);

  logic          v8;
  logic [TW-1:0] r8_tnew, r8_dd;
  logic          r8_cneg, r8_clip, r8_zero;
  logic [GW-1:0] r8_g;
  logic [FW-1:0] r8_emis, r8_absb;

  always_ff @(posedge clk) begin
    if (adv) begin
      r8_tnew <= c8_tnew;
      r8_cneg <= c8_tnew < c8.tint;
      r8_dd   <= (c8_tnew < c8.tint) ? (c8.tint - c8_tnew) : (c8_tnew - c8.tint);
      r8_clip <= c8.clip | c8_tclip;
      r8_zero <= c8.zero_g;
      r8_g    <= c8.g;
      r8_emis <= c8.emis;
      r8_absb <= c8.absb;
    end
  end

  // ---------------------------------------------------------------- stage 9
  logic             v9;
  logic [GH+TW-1:0] r9_clo, r9_chi;
  logic [TW-1:0]    r9_tnew;
  logic             r9_cneg, r9_clip, r9_zero;
  logic [FW-1:0]    r9_emis, r9_absb;

  always_ff @(posedge clk) begin
    if (adv) begin
      r9_clo  <= (GH+TW)'(r8_g[GH-1:0]) * (GH+TW)'(r8_dd);
      r9_chi  <= (GH+TW)'(r8_g[GW-1:GH]) * (GH+TW)'(r8_dd);
      r9_tnew <= r8_tnew;
      r9_cneg <= r8_cneg;
      r9_clip <= r8_clip;
      r9_zero <= r8_zero;
      r9_emis <= r8_emis;
      r9_absb <= r8_absb;
    end
  end

  // ---------------------------------------------------------------- output
  logic [CPW-1:0] c10_cprod;
  logic [CVW-1:0] c10_cv;
  logic [FW-1:0]  c10_lim, c10_cm, c10_cond;
  logic           c10_clip;
  assign c10_cprod = CPW'(r9_clo) + (CPW'(r9_chi) << GH);
  assign c10_cv    = CVW'(c10_cprod >> rseb_pkg::G_FRAC);
  assign c10_lim   = r9_cneg ? LIM_NEG : LIM_POS;
  assign c10_clip  = !r9_zero && (c10_cv > CVW'(c10_lim));
  assign c10_cm    = (c10_cv > CVW'(c10_lim)) ? c10_lim : c10_cv[FW-1:0];
  assign c10_cond  = r9_zero ? '0 : r9_cneg ? (~c10_cm + FW'(1)) : c10_cm;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= OUT_W'({r9_zero, r9_clip | c10_clip, c10_cond,
                              r9_absb, r9_emis, r9_tnew});
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NST; i++) dv_v[i] <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
      dv_v[0] <= v7;
      for (int i = 1; i < NST; i++) dv_v[i] <= dv_v[i-1];
      v8 <= dv_v[NST-1];
      v9 <= v8;
      m_axis_tvalid <= v9;
    end
  end

endmodule

@@ hw/rtl/rseb_checker.sv @@
// Port-level checks for the surface energy balance block, with its bind.
module rseb_checker #(
  parameter int TEMP_WIDTH = 18
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((3*TEMP_WIDTH+120+7)/8)*8-1:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((TEMP_WIDTH+122+7)/8)*8-1:0] m_axis_tdata,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic [rseb_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [rseb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COND_LO  = TEMP_WIDTH + 2*rseb_pkg::FLUX_W;
  localparam int ZERO_BIT = TEMP_WIDTH + 3*rseb_pkg::FLUX_W + 1;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  a_zero_cond: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[ZERO_BIT] |->
      m_axis_tdata[COND_LO +: rseb_pkg::FLUX_W] == '0)
    else $error("conduction flux nonzero with zero conductance");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled although output slot is free");

endmodule

bind radiative_surface_energy_balance rseb_checker #(.TEMP_WIDTH(TEMP_WIDTH)) u_rseb_checker (.*);

@@ sim/radiative_surface_energy_balance_tb.sv @@
// Testbench for the radiative surface energy balance pipeline.
`timescale 1ns / 1ps

module radiative_surface_energy_balance_tb;

  localparam int TW   = 18;
  localparam int IN_W  = ((3*TW+120+7)/8)*8;
  localparam int OUT_W = ((TW+122+7)/8)*8;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  // Face balance scoreboard: predicts each face's result, checks results in order.
  class face_balance_sb;
    bit [rseb_pkg::FACTOR_W-1:0] flux_factor;
    bit [rseb_pkg::SIGMA_W-1:0]  sigma;
    bit [OUT_W-1:0]    pending_q[$];
    int mismatches, faces_in, results_ok, sat_seen, zero_g_seen;

    function void reset_regs();
      flux_factor = rseb_pkg::FLUX_FACTOR_RST;
      sigma       = rseb_pkg::SIGMA_RST;
    endfunction

    function void write_reg(bit [rseb_pkg::CFG_IDX_W-1:0] idx,
                            bit [rseb_pkg::CFG_DATA_W-1:0] val);
      if (idx == rseb_pkg::REG_FLUX_FACTOR) flux_factor = val[rseb_pkg::FACTOR_W-1:0];
      else if (idx == rseb_pkg::REG_STEFAN_BOLTZMANN) sigma = val[rseb_pkg::SIGMA_W-1:0];
    endfunction

    // magnitude >> sh, clipped to the 40-bit signed range, then signed
    function bit [rseb_pkg::FLUX_W-1:0] clip_flux(bit neg, bit [255:0] mag, int sh,
                                                  inout bit clip);
      bit [255:0] v, lim;
      v = mag >> sh;
      lim = neg ? (256'd1 << (rseb_pkg::FLUX_W-1)) : ((256'd1 << (rseb_pkg::FLUX_W-1)) - 1);
      if (v > lim) begin
        v = lim;
        clip = 1;
      end
      return neg ? -v[rseb_pkg::FLUX_W-1:0] : v[rseb_pkg::FLUX_W-1:0];
    endfunction

    function bit [OUT_W-1:0] balance(bit [IN_W-1:0] d);
      bit [TW-1:0] t, tint, tb, tnew, dtemp;
      bit [rseb_pkg::FLUX_W-1:0] qraw, emis, absb, cond;
      bit [15:0] eps, alpha;
      bit [63:0] k, inv, g, smag, dt;
      bit [255:0] hi, lo, prod;
      bit neg, clip, zg;
      longint sum, tn;
      bit [OUT_W-1:0] r;
      t = d[TW-1:0];
      tint = d[2*TW-1:TW];
      tb = d[3*TW-1:2*TW];
      qraw = d[3*TW +: 40];
      eps = d[3*TW+40 +: 16];
      alpha = d[3*TW+56 +: 16];
      k = 64'(d[3*TW+72 +: 24]);
      inv = 64'(d[3*TW+96 +: 24]);
      clip = 0;
      zg = 0;
      cond = 0;
      // emission: sign negative only when the face is hotter than background
      hi = 256'((t >= tb) ? t : tb);
      lo = 256'((t >= tb) ? tb : t);
      hi = hi * hi * hi * hi;
      lo = lo * lo * lo * lo;
      prod = (hi - lo) * 256'(eps) * 256'(sigma);
      emis = clip_flux(t > tb, prod, rseb_pkg::EMIS_SHIFT, clip);
      // absorption
      neg = qraw[rseb_pkg::FLUX_W-1];
      prod = neg ? ((256'd1 << rseb_pkg::FLUX_W) - 256'(qraw)) : 256'(qraw);
      prod = prod * 256'(flux_factor) * 256'(alpha);
      absb = clip_flux(neg, prod, rseb_pkg::ABS_SHIFT, clip);
      sum = longint'($signed(emis)) + longint'($signed(absb));
      g = k * inv;
      if (g == 0) begin
        zg = 1;
        tnew = tint;
      end else begin
        smag = (sum < 0) ? -sum : sum;
        dt = (smag << rseb_pkg::G_FRAC) / g;
        tn = (sum < 0) ? longint'(tint) - longint'(dt) : longint'(tint) + longint'(dt);
        if (tn < 0) begin
          tn = 0;
          clip = 1;
        end else if (tn > (longint'(1) << TW) - 1) begin
          tn = (longint'(1) << TW) - 1;
          clip = 1;
        end
        tnew = tn[TW-1:0];
        neg = tnew < tint;
        dtemp = neg ? tint - tnew : tnew - tint;
        prod = 256'(g);
        prod = prod * 256'(dtemp);
        cond = clip_flux(neg, prod, rseb_pkg::G_FRAC, clip);
      end
      r = '0;
      r[TW-1:0] = tnew;
      r[TW +: 40] = emis;
      r[TW+40 +: 40] = absb;
      r[TW+80 +: 40] = cond;
      r[TW+120] = clip;
      r[TW+121] = zg;
      return r;
    endfunction

    function void note_face(bit [IN_W-1:0] d);
      pending_q.push_back(balance(d));
      faces_in++;
    endfunction

    function void check_result(bit [OUT_W-1:0] got);
      bit [OUT_W-1:0] exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got[TW+121:0] !== exp_r[TW+121:0]) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch");
          $display("  temp exp %0d got %0d", exp_r[TW-1:0], got[TW-1:0]);
          $display("  emis exp %0d got %0d", $signed(exp_r[TW +: 40]), $signed(got[TW +: 40]));
          $display("  abs  exp %0d got %0d", $signed(exp_r[TW+40 +: 40]),
                   $signed(got[TW+40 +: 40]));
          $display("  cond exp %0d got %0d", $signed(exp_r[TW+80 +: 40]),
                   $signed(got[TW+80 +: 40]));
          $display("  sat exp %0b got %0b, zero_g exp %0b got %0b",
                   exp_r[TW+120], got[TW+120], exp_r[TW+121], got[TW+121]);
        end
      end else begin
        results_ok++;
        sat_seen += got[TW+120];
        zero_g_seen += got[TW+121];
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [rseb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rseb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  face_balance_sb sb;
  bit no_idle = 0;          // stretch with no idling on either side
  int hold_cycles = 0;      // long receiver hold-off, counted down below
  int cycle_count = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  radiative_surface_energy_balance #(.TEMP_WIDTH(TW)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Monitor: note accepted faces, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_face(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: random stalls, plus a counted long hold-off on request
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_cycles > 0) begin
      m_axis_tready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else if (no_idle) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               sb.pending_q.size());
      $display("radiative_surface_energy_balance_tb failed");
      $finish;
    end
  end

  function automatic bit [IN_W-1:0] pack_face(bit [TW-1:0] t, tint, tb, bit [39:0] q,
                                               bit [15:0] eps, alpha, bit [23:0] k, inv);
    return IN_W'({inv, k, alpha, eps, q, tb, tint, t});
  endfunction

  function automatic bit [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  // Mostly physical faces with random content; some full-range noise and zero G
  function automatic bit [IN_W-1:0] random_face();
    int mode;
    bit [39:0] q;
    mode = $urandom_range(99);
    if (mode < 70) begin
      q = 40'($urandom_range(1 << 20));
      if ($urandom_range(1)) q = -q;
      return pack_face(TW'($urandom_range(48000, 3200)), TW'($urandom_range(48000, 3200)),
                       TW'($urandom_range(48000, 0)), q, 16'($urandom), 16'($urandom),
                       24'($urandom_range(1 << 20, 1 << 12)),
                       24'($urandom_range(1 << 16, 1 << 4)));
    end else if (mode < 90) begin
      return pack_face(TW'($urandom), TW'($urandom), TW'($urandom), rand40(),
                       16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
    end else begin
      return pack_face(TW'($urandom), TW'($urandom), TW'($urandom), rand40(),
                       16'($urandom), 16'($urandom),
                       $urandom_range(1) ? 24'd0 : 24'($urandom),
                       $urandom_range(1) ? 24'd0 : 24'($urandom));
    end
  endfunction

  // Offer one face; called and returns at a falling edge
  task automatic send_face(bit [IN_W-1:0] d);
    if (!no_idle) begin
      while ($urandom_range(99) < 19) begin
        s_axis_tvalid = 0;
        @(negedge clk);
      end
    end
    s_axis_tvalid = 1;
    s_axis_tdata = d;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_cfg(bit [rseb_pkg::CFG_IDX_W-1:0] idx,
                           bit [rseb_pkg::CFG_DATA_W-1:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Pause the sender until every result is in, then let the pipe empty
  task automatic drain();
    s_axis_tvalid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    bit [39:0] qmin, qmax;
    sb = new();
    sb.reset_regs();
    qmin = 40'h80_0000_0000;
    qmax = 40'h7F_FFFF_FFFF;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed faces: field extremes, sign of emission, zero G, temperature clipping
    send_face(pack_face(0, 0, 0, 0, 0, 0, 0, 0));
    send_face(pack_face('1, '1, '1, qmax, '1, '1, '1, '1));
    send_face(pack_face('1, '1, 0, qmin, '1, '1, '1, '1));
    send_face(pack_face(0, '1, '1, qmax, '1, '1, 1, 1));
    send_face(pack_face(4800, 4800, 4800, 1600, 60000, 50000, 65536, 160));
    send_face(pack_face(16000, 4800, 4800, 0, 60000, 0, 65536, 160));
    send_face(pack_face(4800, 4800, 16000, -40'sd1600, 30000, 50000, 65536, 160));
    send_face(pack_face(5000, 5000, 300, 0, 65535, 0, 0, 12345));
    send_face(pack_face(5000, 5000, 300, 5000, 65535, 65535, 12345, 0));
    send_face(pack_face(5000, 100, 300, qmin, 0, 65535, 1, 1));
    send_face(pack_face(5000, '1, 300, qmax, 0, 65535, 1, 1));
    send_face(pack_face('1, 0, 0, 0, 65535, 0, 1, 1));
    send_face(pack_face(0, 0, '1, 0, 65535, 0, 1, 1));
    send_face(pack_face(1, 2, 3, 1, 1, 1, 1, 1));
    send_face(pack_face('1, '1, '1, -40'sd1, 65535, 65535, '1, 1));
    send_face(pack_face(3200, 6400, 0, qmax, 65535, 65535, 24'hFFFFFF, 24'hFFFFFF));
    send_face(pack_face(3200, 6400, 0, qmin, 65535, 65535, 24'hFFFFFF, 24'hFFFFFF));
    send_face(pack_face(18'h2AAAA, 18'h15555, 18'h2AAAA, 40'h55_5555_5555, 16'hAAAA,
                        16'h5555, 24'hAAAAAA, 24'h555555));
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      // Reconfigure between phases: extremes, random, masked data, bad index
      case (p)
        1: begin
          write_cfg(rseb_pkg::REG_FLUX_FACTOR, 24'hFFFFFF);  // upper bits masked off
          write_cfg(rseb_pkg::REG_STEFAN_BOLTZMANN, 24'hFFFFFF);
        end
        2: begin
          write_cfg(rseb_pkg::REG_FLUX_FACTOR, 0);
          write_cfg(rseb_pkg::REG_STEFAN_BOLTZMANN, 0);
        end
        3: begin
          write_cfg(rseb_pkg::REG_FLUX_FACTOR, rseb_pkg::CFG_DATA_W'($urandom));
          write_cfg(rseb_pkg::REG_STEFAN_BOLTZMANN, rseb_pkg::CFG_DATA_W'($urandom));
          write_cfg(rseb_pkg::CFG_IDX_W'(7), rseb_pkg::CFG_DATA_W'($urandom));  // ignored
        end
        4: begin
          write_cfg(rseb_pkg::REG_FLUX_FACTOR,
                    rseb_pkg::CFG_DATA_W'(rseb_pkg::FLUX_FACTOR_RST));
          write_cfg(rseb_pkg::REG_STEFAN_BOLTZMANN, rseb_pkg::SIGMA_RST);
        end
        5: write_cfg(rseb_pkg::REG_FLUX_FACTOR, 24'h008000);
        default: ;
      endcase
      if (p == 2) hold_cycles = 300;  // long receiver hold-off: pipe fills, input stalls
      no_idle = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) send_face(random_face());
      drain();
    end
    no_idle = 0;

    if (sb.pending_q.size() != 0) begin
      sb.mismatches++;
      $display("ERROR: %0d expected results never arrived", sb.pending_q.size());
    end
    $display("%0d faces in, %0d results matched, %0d saturated, %0d zero conductance",
             sb.faces_in, sb.results_ok, sb.sat_seen, sb.zero_g_seen);
    $display("covered %0d register settings, stall and drain pressure; %0d mismatches",
             N_PHASES + 1, sb.mismatches);
    if (sb.mismatches == 0) $display("radiative_surface_energy_balance_tb passed");
    else $display("radiative_surface_energy_balance_tb failed");
    $finish;
  end

endmodule

@@ radiative_surface_energy_balance.f @@
hw/rtl/rseb_pkg.sv
hw/rtl/radiative_surface_energy_balance.sv
hw/rtl/rseb_checker.sv
sim/radiative_surface_energy_balance_tb.sv
